FILE: rtl/tadr_pkg.sv
package tadr_pkg;

  // sample width default, legal range 8 to 13
  localparam int SAMPLE_BITS_DEF = 10;

  // threshold registers
  localparam int THR_BITS      = 10;
  localparam logic [THR_BITS-1:0] HIGH_THR_RESET = 10'd700;
  localparam logic [THR_BITS-1:0] LOW_THR_RESET  = 10'd400;

  // apb register map, one register per 32-bit word
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

  // decimal digits: at most four for a 13-bit sample
  localparam int MAX_DIGITS = 4;
  localparam int ND_W       = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

  // divide by ten as multiply by reciprocal, exact below 43699
  localparam int RECIP_BITS = 16;
  localparam logic [RECIP_BITS-1:0] RECIP_TEN = 16'd52429;
  localparam int DIV_SHIFT  = 19;

  // label text
  localparam int LABEL_IDX_W = 4;
  localparam logic [8*8-1:0]  LABEL_HIGH   = " HIGH : ";
  localparam logic [8*7-1:0]  LABEL_LOW    = " LOW : ";
  localparam logic [8*10-1:0] LABEL_NORMAL = " NORMAL : ";
  localparam logic [7:0]      ASCII_ZERO   = 8'h30;

  typedef enum logic [1:0] {
    CLASS_NORMAL = 2'd0,
    CLASS_HIGH   = 2'd1,
    CLASS_LOW    = 2'd2
  } class_t;

  // microprogram
  typedef logic [1:0] step_t;
  localparam step_t STEP_POLL   = 2'd0;
  localparam step_t STEP_DIVIDE = 2'd1;
  localparam step_t STEP_LABEL  = 2'd2;
  localparam step_t STEP_DIGIT  = 2'd3;

  typedef enum logic [1:0] {
    COND_NO_PRESS,
    COND_MORE_DIGITS,
    COND_LABEL_MORE,
    COND_DIGIT_MORE
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  divide;
    logic  emit_label;
    logic  emit_digit;
    cond_t cond;
    step_t target;
  } uword_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic fire;
    logic take_in;
    logic divide;
    logic emit_label;
    logic emit_digit;
  } ctl_t;

  // flags from datapath to sequencer
  typedef struct packed {
    logic press;
    logic more_digits;
    logic label_more;
    logic digit_more;
  } status_t;

  // control store: a taken condition jumps to target, else fall through
  function automatic uword_t ucode(input step_t pc);
    uword_t uw;
    uw = '0;
    unique case (pc)
      STEP_POLL: begin
        uw.take_in = 1'b1;
        uw.cond    = COND_NO_PRESS;
        uw.target  = STEP_POLL;
      end
      STEP_DIVIDE: begin
        uw.divide = 1'b1;
        uw.cond   = COND_MORE_DIGITS;
        uw.target = STEP_DIVIDE;
      end
      STEP_LABEL: begin
        uw.emit_label = 1'b1;
        uw.cond       = COND_LABEL_MORE;
        uw.target     = STEP_LABEL;
      end
      STEP_DIGIT: begin
        uw.emit_digit = 1'b1;
        uw.cond       = COND_DIGIT_MORE;
        uw.target     = STEP_DIGIT;
      end
      default: uw = '0;
    endcase
    return uw;
  endfunction

  function automatic logic [LABEL_IDX_W-1:0] label_len(input class_t cls);
    logic [LABEL_IDX_W-1:0] len;
    unique case (cls)
      CLASS_HIGH: len = LABEL_IDX_W'(8);
      CLASS_LOW:  len = LABEL_IDX_W'(7);
      default:    len = LABEL_IDX_W'(10);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] label_char(input class_t cls,
                                            input logic [LABEL_IDX_W-1:0] idx);
    logic [7:0] ch;
    int pos;
    ch  = 8'h20;
    pos = int'(idx);
    unique case (cls)
      CLASS_HIGH: if (pos < 8) ch = LABEL_HIGH[8*(7-pos) +: 8];
      CLASS_LOW:  if (pos < 7) ch = LABEL_LOW[8*(6-pos) +: 8];
      default:    if (pos < 10) ch = LABEL_NORMAL[8*(9-pos) +: 8];
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/threshold_alarm_decimal_reporter.sv
// threshold alarm with decimal report: each input word carries a button level
// and a converter sample; on the first pressed word after a release the sample
// is classified against the high and low thresholds (high tested first) and a
// report goes out one byte per output word: the label " HIGH : ", " LOW : " or
// " NORMAL : " followed by the sample's decimal digits, most significant first,
// with last_byte marking the final byte (a zero sample gives the digit "0").
// level_class and lamp hold steady over the whole report; lamp is the led level
// after the report (set on high, cleared on low, kept on normal). a word that
// is not a press edge is taken and produces nothing. a press is accepted,
// then the divide-by-ten loop yields one decimal digit (1 to 4) per step,
// then one output byte (8 to 14) goes out per step, each held while
// out_ready is low; the microcoded sequencer runs one step at a time.
// no input word is taken while a report is being sent. thresholds are
// written through the apb port at byte 0 (high) and byte 4 (low), only while
// the block is idle; the user must keep to this, the block does not enforce it.
module threshold_alarm_decimal_reporter
  import tadr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   button_level,
  input  logic [SAMPLE_BITS-1:0] sample,

  // output words, one per report byte
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             text_byte,
  output logic                   last_byte,
  output logic [1:0]             level_class,
  output logic                   lamp,

  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [THR_BITS-1:0] high_thr;
  logic [THR_BITS-1:0] low_thr;
  ctl_t                ctl;
  status_t             status;

  // threshold registers
  tadr_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .high_thr (high_thr),
    .low_thr  (low_thr)
  );

  // step counter and control store: poll, divide loop, label loop, digit loop
  tadr_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  // arming, classification, divide by ten, digit store and byte select
  tadr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .button_level (button_level),
    .sample       (sample),
    .high_thr     (high_thr),
    .low_thr      (low_thr),
    .status       (status),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .level_class  (level_class),
    .lamp         (lamp)
  );

  // input is only taken between reports
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a report is in flight");

  // the last byte of a report returns the block to polling
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte |=> in_ready)
    else $error("block did not return to polling after last byte");

  // the led level only moves on an accepted input word
  a_lamp_on_accept: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(lamp) |-> $past(in_valid && in_ready))
    else $error("lamp changed without an accepted input word");

endmodule

FILE: rtl/tadr_regs.sv
module tadr_regs
  import tadr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [THR_BITS-1:0]   high_thr,
  output logic [THR_BITS-1:0]   low_thr
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_thr <= HIGH_THR_RESET;
      low_thr  <= LOW_THR_RESET;
    end else if (wr_en) begin
      if (reg_idx == REG_HIGH_THR) high_thr <= pwdata[THR_BITS-1:0];
      if (reg_idx == REG_LOW_THR)  low_thr  <= pwdata[THR_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIGH_THR: prdata = APB_DATA_W'(high_thr);
      REG_LOW_THR:  prdata = APB_DATA_W'(low_thr);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: rtl/tadr_useq.sv
module tadr_useq
  import tadr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_ready,
  input  status_t status,
  output logic    in_ready,
  output logic    out_valid,
  output ctl_t    ctl
);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   fire;
  logic   taken;

  assign uw = ucode(pc);

  always_ff @(posedge clk) begin
    if (rst) pc <= STEP_POLL;
    else     pc <= pc_next;
  end

  always_comb begin
    in_ready  = uw.take_in;
    out_valid = uw.emit_label || uw.emit_digit;
    if (uw.take_in)    fire = in_valid;
    else if (out_valid) fire = out_ready;
    else               fire = 1'b1;

    unique case (uw.cond)
      COND_NO_PRESS:    taken = !status.press;
      COND_MORE_DIGITS: taken = status.more_digits;
      COND_LABEL_MORE:  taken = status.label_more;
      COND_DIGIT_MORE:  taken = status.digit_more;
      default:          taken = 1'b0;
    endcase

    pc_next = pc;
    if (fire) pc_next = taken ? uw.target : pc + step_t'(1);

    ctl.fire       = fire;
    ctl.take_in    = uw.take_in;
    ctl.divide     = uw.divide;
    ctl.emit_label = uw.emit_label;
    ctl.emit_digit = uw.emit_digit;
  end

endmodule

FILE: rtl/tadr_datapath.sv
module tadr_datapath
  import tadr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  input  logic                   button_level,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [THR_BITS-1:0]    high_thr,
  input  logic [THR_BITS-1:0]    low_thr,
  output status_t                status,
  output logic [7:0]             text_byte,
  output logic                   last_byte,
  output logic [1:0]             level_class,
  output logic                   lamp
);

  localparam int CMP_W  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int PROD_W = SAMPLE_BITS + RECIP_BITS;

  logic                   armed;
  logic                   lamp_state;
  class_t                 cls;
  logic [SAMPLE_BITS-1:0] val;
  logic [ND_W-1:0]        nd;
  logic [LABEL_IDX_W-1:0] lidx;
  logic [3:0]             dig [MAX_DIGITS];

  logic [CMP_W-1:0]       s_ext;
  logic                   is_high;
  logic                   is_low;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] rem_full;
  logic [ND_W-1:0]        nd_m1;

  assign s_ext   = CMP_W'(sample);
  assign is_high = s_ext > CMP_W'(high_thr);
  assign is_low  = s_ext < CMP_W'(low_thr);

  // val / 10 and val % 10
  assign prod     = PROD_W'(val) * PROD_W'(RECIP_TEN);
  assign quot     = SAMPLE_BITS'(prod >> DIV_SHIFT);
  assign rem_full = val - (quot << 3) - (quot << 1);
  assign nd_m1    = nd - ND_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b1;
      lamp_state <= 1'b0;
      cls        <= CLASS_NORMAL;
    end else if (ctl.fire && ctl.take_in) begin
      if (!button_level) begin
        armed <= 1'b1;
      end else if (armed) begin
        armed <= 1'b0;
        if (is_high) begin
          cls        <= CLASS_HIGH;
          lamp_state <= 1'b1;
        end else if (is_low) begin
          cls        <= CLASS_LOW;
          lamp_state <= 1'b0;
        end else begin
          cls <= CLASS_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      if (ctl.take_in) begin
        val  <= sample;
        nd   <= '0;
        lidx <= '0;
      end
      if (ctl.divide) begin
        dig[nd[DIG_IDX_W-1:0]] <= rem_full[3:0];
        val                    <= quot;
        nd                     <= nd + ND_W'(1);
      end
      if (ctl.emit_label) lidx <= lidx + LABEL_IDX_W'(1);
      if (ctl.emit_digit) nd   <= nd_m1;
    end
  end

  always_comb begin
    status.press       = button_level && armed;
    status.more_digits = (quot != '0) && (nd != ND_W'(MAX_DIGITS - 1));
    status.label_more  = lidx != (label_len(cls) - LABEL_IDX_W'(1));
    status.digit_more  = nd != ND_W'(1);

    if (ctl.emit_label) text_byte = label_char(cls, lidx);
    else                text_byte = ASCII_ZERO | 8'(dig[nd_m1[DIG_IDX_W-1:0]]);
    last_byte   = ctl.emit_digit && (nd == ND_W'(1));
    level_class = cls;
    lamp        = lamp_state;
  end

endmodule

FILE: tb/tb_threshold_alarm_decimal_reporter.sv
`timescale 1ns / 100ps

module tb_threshold_alarm_decimal_reporter;
  import tadr_pkg::*;

  localparam int SMP_W        = SAMPLE_BITS_DEF;
  localparam int MAX_GAP      = 15;
  // settle margin, longer than a press or a non-press word keeps the sequencer busy
  localparam int SETTLE_CYCLES = 24;
  // long receiver stall, well past one full report
  localparam int LONG_HOLD    = 300;

  // one expected output word: a single report byte with its side fields
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    class_t     cls;
    logic       led;
  } report_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid;
  logic             in_ready;
  logic             button_level;
  logic [SMP_W-1:0] sample;

  logic       out_valid;
  logic       out_ready;
  logic [7:0] text_byte;
  logic       last_byte;
  logic [1:0] level_class;
  logic       lamp;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  threshold_alarm_decimal_reporter #(
    .SAMPLE_BITS(SMP_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .button_level(button_level),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_byte   (text_byte),
    .last_byte   (last_byte),
    .level_class (level_class),
    .lamp        (lamp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic              armed    = 1'b1;
  logic              lamp_on  = 1'b0;
  logic [THR_BITS-1:0] high_thr = HIGH_THR_RESET;
  logic [THR_BITS-1:0] low_thr  = LOW_THR_RESET;

  report_char_t report_q[$];   // bytes still owed by the block, oldest first
  int unsigned  fail_count = 0;
  int unsigned  words_sent = 0;

  // idling knobs for sender and receiver
  bit in_gap_on     = 1'b1;
  bit out_gap_on    = 1'b1;
  bit long_hold_req = 1'b0;

  // work out the report that one accepted word causes, if any
  task automatic predict_report(input logic btn, input logic [SMP_W-1:0] smp);
    string        text;
    class_t       cls;
    report_char_t rc;
    if (!btn) begin
      // released button re-arms the press detector
      armed = 1'b1;
      return;
    end
    if (!armed) return;  // still held from the last press
    armed = 1'b0;
    // high is tested first, so it wins when the thresholds cross
    if (smp > high_thr) begin
      cls     = CLASS_HIGH;
      lamp_on = 1'b1;
      text    = " HIGH : ";
    end else if (smp < low_thr) begin
      cls     = CLASS_LOW;
      lamp_on = 1'b0;
      text    = " LOW : ";
    end else begin
      cls  = CLASS_NORMAL;
      text = " NORMAL : ";
    end
    // decimal digits, most significant first; zero gives a single "0"
    text = {text, $sformatf("%0d", smp)};
    for (int i = 0; i < text.len(); i++) begin
      rc.ch      = text[i];
      rc.is_last = (i == text.len() - 1);
      rc.cls     = cls;
      rc.led     = lamp_on;
      report_q.push_back(rc);
    end
  endtask

  // offer one input word, hold it until accepted, then predict its report;
  // returns at the accepting edge so the next call can keep valid high
  task automatic send_word(input logic btn, input logic [SMP_W-1:0] smp);
    int gap;
    gap = in_gap_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    sample       <= smp;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    predict_report(btn, smp);
  endtask

  // release with junk sample, then press: one well-formed report request
  task automatic press_release(input logic [SMP_W-1:0] smp);
    send_word(1'b0, SMP_W'($urandom));
    send_word(1'b1, smp);
  endtask

  // drop valid and wait until every expected byte is out and the block settles
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write: setup then access phase; junk in the bits above the register
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [THR_BITS-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h3ff) | APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_HIGH_THR) high_thr = val;
    else if (idx == REG_LOW_THR) low_thr = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    // lean toward short numbers now and then so every digit count shows up
    if ($urandom_range(0, 3) == 0) return SMP_W'($urandom_range(0, 99));
    return SMP_W'($urandom_range(0, (1 << SMP_W) - 1));
  endfunction

  // receiver: random stall before each word, plus one long hold on request
  initial begin : receiver
    int pause;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      pause = out_gap_on ? $urandom_range(0, MAX_GAP) : 0;
      if (long_hold_req) begin
        pause += LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every accepted output word against the oldest expected byte
  always @(posedge clk) begin : byte_checker
    report_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected word text_byte %h last_byte %b", $time,
                 text_byte, last_byte);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        if (text_byte !== want.ch) begin
          $display("%0t: text_byte expected %h got %h", $time, want.ch, text_byte);
          fail_count++;
        end
        if (last_byte !== want.is_last) begin
          $display("%0t: last_byte expected %b got %b", $time, want.is_last,
                   last_byte);
          fail_count++;
        end
        if (level_class !== want.cls) begin
          $display("%0t: level_class expected %0d got %0d", $time, want.cls,
                   level_class);
          fail_count++;
        end
        if (lamp !== want.led) begin
          $display("%0t: lamp expected %b got %b", $time, want.led, lamp);
          fail_count++;
        end
      end
    end
  end

  // reset thresholds: boundaries, digit counts, zero, held button
  task automatic test_directed();
    send_word(1'b1, '0);            // zero sample, low, lamp stays off
    send_word(1'b1, SMP_W'(555));   // button still held: nothing
    send_word(1'b0, '1);
    send_word(1'b1, '1);            // largest sample, high
    press_release(SMP_W'(700));     // equal to high threshold: normal
    press_release(SMP_W'(701));
    press_release(SMP_W'(400));     // equal to low threshold: normal, lamp kept
    press_release(SMP_W'(399));
    press_release(SMP_W'(9));
    press_release(SMP_W'(10));
    press_release(SMP_W'(99));
    press_release(SMP_W'(100));
    press_release(SMP_W'(999));
  endtask

  // one threshold setting, probed around both thresholds and at random
  task automatic run_setting(input logic [THR_BITS-1:0] hi,
                             input logic [THR_BITS-1:0] lo, input int pairs);
    wait_idle();
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_LOW_THR, lo);
    press_release(hi);
    press_release(hi + 1'b1);
    press_release(lo);
    press_release(lo - 1'b1);
    press_release('0);
    press_release('1);
    repeat (pairs) press_release(rand_sample());
  endtask

  // threshold extremes, crossed thresholds, random settings, back to reset values
  task automatic test_threshold_sweep();
    run_setting('0, '1, 6);          // crossed: high wins wherever both hold
    run_setting('1, '0, 6);          // nothing high or low
    run_setting(10'd512, 10'd512, 6);
    run_setting(THR_BITS'($urandom), THR_BITS'($urandom), 6);
    run_setting(THR_BITS'($urandom), THR_BITS'($urandom), 6);
    run_setting(HIGH_THR_RESET, LOW_THR_RESET, 2);
  endtask

  // mostly release/press pairs, some raw words with random button levels
  task automatic test_random_reports(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) send_word(1'($urandom), SMP_W'($urandom));
      else press_release(rand_sample());
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    in_gap_on     = 1'b0;
    long_hold_req = 1'b1;
    repeat (10) press_release(rand_sample());
    in_gap_on = 1'b1;
  endtask

  // sender stops until the block has drained, then resumes
  task automatic test_pause_drain();
    repeat (4) press_release(rand_sample());
    wait_idle();
    repeat (4) press_release(rand_sample());
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    in_gap_on  = 1'b0;
    out_gap_on = 1'b0;
    repeat (30) press_release(rand_sample());
    in_gap_on  = 1'b1;
    out_gap_on = 1'b1;
  endtask

  initial begin
    in_valid     = 1'b0;
    button_level = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_sweep();
    test_random_reports(190);
    test_output_backpressure();
    test_pause_drain();
    test_back_to_back();
    test_random_reports(40);

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tadr_pkg.sv
rtl/tadr_regs.sv
rtl/tadr_useq.sv
rtl/tadr_datapath.sv
rtl/threshold_alarm_decimal_reporter.sv
tb/tb_threshold_alarm_decimal_reporter.sv
